@@ hdl/tsq_pkg.sv @@
// ----------------------------------------------------------------------------
// tsq_pkg: shared constants for the tetrahedron shape quality core
// Default widths, the fixed-point quality scale and output field widths.
// ----------------------------------------------------------------------------
package tsq_pkg;

	localparam int COORD_BITS_DEF        = 16;
	localparam int QUALITY_FRAC_BITS_DEF = 16;

	// coordinate bits plus guard bits of the square root inputs
	localparam int GUARD_SUM = 32;

	// 2*sqrt(6) scaled by 2^K_FRAC
	localparam int K_FRAC = 24;
	localparam int K_W    = 27;
	localparam logic [K_W-1:0] K_FIXED = 27'd82191237;

	localparam int SIX_VOLUME_W = 51;

endpackage

@@ hdl/tsq_geom.sv @@
// ----------------------------------------------------------------------------
// tsq_geom: edge vectors, cross products, determinant and edge lengths
// Six register stages; yields squared face normals, longest squared edge
// and the magnitude of the edge-vector determinant.
// ----------------------------------------------------------------------------
module tsq_geom
#(
	parameter int COORD_W = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       v_i,
	input  logic signed [COORD_W-1:0]  pt [4][3],
	output logic                       v_o,
	output logic [4*COORD_W+5:0]       n2 [4],
	output logic [2*COORD_W+1:0]       lmax2,
	output logic [3*COORD_W+4:0]       det_mag
);

	localparam int DW   = COORD_W + 1;
	localparam int PW   = 2 * DW;
	localparam int CW   = PW + 1;
	localparam int MW   = CW - 1;
	localparam int FSW  = 2 * MW;
	localparam int NW   = FSW + 2;
	localparam int DPW  = DW + CW;
	localparam int DETW = DPW + 2;
	localparam int SQW  = 2 * COORD_W;
	localparam int LW   = SQW + 2;

	// edges: 01 02 03 12 13 23
	localparam int EA [6] = '{0, 0, 0, 1, 1, 2};
	localparam int EB [6] = '{1, 2, 3, 2, 3, 3};
	// cross operands (edge indexes): determinant, then faces 012 123 230 301
	localparam int XU [5] = '{1, 0, 3, 5, 2};
	localparam int XV [5] = '{2, 1, 4, 1, 4};

	logic [5:0] vld_s;

	logic signed [DW-1:0]   dif_s1 [6][3];
	logic signed [PW-1:0]   prd_s2 [5][6];
	logic [SQW-1:0]         sq_s2  [6][3];
	logic signed [DW-1:0]   e01_s2 [3];
	logic signed [CW-1:0]   crs_s3 [5][3];
	logic [LW-1:0]          len_s3 [6];
	logic signed [DW-1:0]   e01_s3 [3];
	logic [MW-1:0]          mag_s3 [4][3];
	logic signed [DPW-1:0]  dp_s4  [3];
	logic [FSW-1:0]         fsq_s4 [4][3];
	logic [LW-1:0]          lpm_s4 [3];
	logic signed [DETW-1:0] det_s5;
	logic [NW-1:0]          n2_s5  [4];
	logic [LW-1:0]          lmx_s5;
	logic [DETW-2:0]        det_s6;
	logic [NW-1:0]          n2_s6  [4];
	logic [LW-1:0]          lmx_s6;
	logic [LW-1:0]          lm01, lm2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[4:0], v_i};
		end
	end

	always_comb begin
		for (int f = 0; f < 4; f++) begin
			for (int k = 0; k < 3; k++) begin
				mag_s3[f][k] = crs_s3[f+1][k][CW-1] ? MW'(-crs_s3[f+1][k]) : MW'(crs_s3[f+1][k]);
			end
		end
		lm01 = (lpm_s4[0] > lpm_s4[1]) ? lpm_s4[0] : lpm_s4[1];
		lm2  = lpm_s4[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 6; e++) begin
				for (int j = 0; j < 3; j++) begin
					dif_s1[e][j] <= DW'(pt[EB[e]][j]) - DW'(pt[EA[e]][j]);
				end
			end

			for (int x = 0; x < 5; x++) begin
				prd_s2[x][0] <= dif_s1[XU[x]][1] * dif_s1[XV[x]][2];
				prd_s2[x][1] <= dif_s1[XU[x]][2] * dif_s1[XV[x]][1];
				prd_s2[x][2] <= dif_s1[XU[x]][2] * dif_s1[XV[x]][0];
				prd_s2[x][3] <= dif_s1[XU[x]][0] * dif_s1[XV[x]][2];
				prd_s2[x][4] <= dif_s1[XU[x]][0] * dif_s1[XV[x]][1];
				prd_s2[x][5] <= dif_s1[XU[x]][1] * dif_s1[XV[x]][0];
			end
			for (int e = 0; e < 6; e++) begin
				for (int j = 0; j < 3; j++) begin
					sq_s2[e][j] <= SQW'(dif_s1[e][j]) * SQW'(dif_s1[e][j]);
				end
			end
			for (int j = 0; j < 3; j++) begin
				e01_s2[j] <= dif_s1[0][j];
			end

			for (int x = 0; x < 5; x++) begin
				for (int k = 0; k < 3; k++) begin
					crs_s3[x][k] <= CW'(prd_s2[x][2*k]) - CW'(prd_s2[x][2*k+1]);
				end
			end
			for (int e = 0; e < 6; e++) begin
				len_s3[e] <= LW'(sq_s2[e][0]) + LW'(sq_s2[e][1]) + LW'(sq_s2[e][2]);
			end
			for (int j = 0; j < 3; j++) begin
				e01_s3[j] <= e01_s2[j];
			end

			for (int k = 0; k < 3; k++) begin
				dp_s4[k] <= DPW'(e01_s3[k]) * DPW'(crs_s3[0][k]);
			end
			for (int f = 0; f < 4; f++) begin
				for (int k = 0; k < 3; k++) begin
					fsq_s4[f][k] <= mag_s3[f][k] * mag_s3[f][k];
				end
			end
			for (int p = 0; p < 3; p++) begin
				lpm_s4[p] <= (len_s3[2*p] > len_s3[2*p+1]) ? len_s3[2*p] : len_s3[2*p+1];
			end

			det_s5 <= DETW'(dp_s4[0]) + DETW'(dp_s4[1]) + DETW'(dp_s4[2]);
			for (int f = 0; f < 4; f++) begin
				n2_s5[f] <= NW'(fsq_s4[f][0]) + NW'(fsq_s4[f][1]) + NW'(fsq_s4[f][2]);
			end
			lmx_s5 <= (lm01 > lm2) ? lm01 : lm2;

			det_s6 <= det_s5[DETW-1] ? (DETW-1)'(-det_s5) : (DETW-1)'(det_s5);
			for (int f = 0; f < 4; f++) begin
				n2_s6[f] <= n2_s5[f];
			end
			lmx_s6 <= lmx_s5;
		end
	end

	assign v_o     = vld_s[5];
	assign n2      = n2_s6;
	assign lmax2   = lmx_s6;
	assign det_mag = det_s6;

endmodule

@@ hdl/tsq_roots.sv @@
// ----------------------------------------------------------------------------
// tsq_roots: pipelined integer square roots, several lanes in step
// Digit-by-digit method, one root bit per register stage, ROOT_W stages.
// A sideband word travels alongside with the same latency.
// ----------------------------------------------------------------------------
module tsq_roots
#(
	parameter int ROOT_W = 51,
	parameter int LANES  = 5,
	parameter int SB_W   = 53
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  v_i,
	input  logic [2*ROOT_W-1:0]   rad [LANES],
	input  logic [SB_W-1:0]       sb_i,
	output logic                  v_o,
	output logic [ROOT_W-1:0]     root [LANES],
	output logic [SB_W-1:0]       sb_o
);

	localparam int REM_W = ROOT_W + 2;

	logic [ROOT_W-1:0]   vld_s;
	logic [SB_W-1:0]     sb_s   [ROOT_W];
	logic [2*ROOT_W-1:0] rad_s  [ROOT_W-1][LANES];
	logic [REM_W-1:0]    rem_s  [ROOT_W-1][LANES];
	logic [ROOT_W-1:0]   root_s [ROOT_W][LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[ROOT_W-2:0], v_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[0] <= sb_i;
			for (int k = 1; k < ROOT_W; k++) begin
				sb_s[k] <= sb_s[k-1];
			end
		end
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [2*ROOT_W-1:0] rad_in;
			logic [REM_W-1:0]    rem_in;
			logic [ROOT_W-1:0]   root_in;
			logic [REM_W+1:0]    rem_sh;
			logic [REM_W+1:0]    trial;
			logic                take;

			if (k == 0) begin : g_first
				assign rad_in  = rad[l];
				assign rem_in  = '0;
				assign root_in = '0;
			end else begin : g_next
				assign rad_in  = rad_s[k-1][l];
				assign rem_in  = rem_s[k-1][l];
				assign root_in = root_s[k-1][l];
			end

			assign rem_sh = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
			assign trial  = (REM_W+2)'({root_in, 2'b01});
			assign take   = rem_sh >= trial;

			always_ff @(posedge clk) begin
				if (en) begin
					root_s[k][l] <= {root_in[ROOT_W-2:0], take};
				end
			end

			if (k < ROOT_W - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en) begin
						rad_s[k][l] <= rad_in << 2;
						rem_s[k][l] <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
					end
				end
			end
		end
	end

	assign v_o  = vld_s[ROOT_W-1];
	assign sb_o = sb_s[ROOT_W-1];
	assign root = root_s[ROOT_W-1];

endmodule

@@ hdl/tsq_divider.sv @@
// ----------------------------------------------------------------------------
// tsq_divider: quality quotient
// Forms numerator |D|*K and denominator Lfx*Csum in split products, flags
// degenerate and saturated cases, then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module tsq_divider
	import tsq_pkg::*;
#(
	parameter int ROOT_W = 51,
	parameter int LF_W   = 33,
	parameter int DETM_W = 53,
	parameter int FRAC_W = 16,
	parameter int NUM_SH = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    v_i,
	input  logic [ROOT_W-1:0]       face [4],
	input  logic [LF_W-1:0]         lfx,
	input  logic [DETM_W-1:0]       det_mag,
	output logic                    v_o,
	output logic [FRAC_W:0]         quality,
	output logic [SIX_VOLUME_W-1:0] six_volume,
	output logic                    degenerate
);

	localparam int CS_W  = ROOT_W + 2;
	localparam int CL_W  = (CS_W + 1) / 2;
	localparam int CH_W  = CS_W - CL_W;
	localparam int DL_W  = (DETM_W + 1) / 2;
	localparam int DH_W  = DETM_W - DL_W;
	localparam int NK_W  = DETM_W + K_W;
	localparam int NUM_W = NK_W + NUM_SH;
	localparam int DEN_W = LF_W + CS_W;
	localparam int CMP_W = ((NUM_W > DEN_W + FRAC_W) ? NUM_W : DEN_W + FRAC_W) + 1;
	localparam int VL    = FRAC_W + 5;

	logic [VL-1:0] vld_s;

	logic [CS_W-1:0]         csum_s1;
	logic [LF_W-1:0]         lfx_s1;
	logic [DL_W+K_W-1:0]     nkl_s1;
	logic [DH_W+K_W-1:0]     nkh_s1;
	logic                    deg_s1;
	logic [SIX_VOLUME_W-1:0] sv_s1;

	logic [LF_W+CL_W-1:0]    dpl_s2;
	logic [LF_W+CH_W-1:0]    dph_s2;
	logic [NK_W-1:0]         nk_s2;
	logic                    deg_s2;
	logic [SIX_VOLUME_W-1:0] sv_s2;

	logic [DEN_W-1:0]        den_s3;
	logic [NUM_W-1:0]        num_s3;
	logic                    deg_s3;
	logic [SIX_VOLUME_W-1:0] sv_s3;

	logic [DEN_W-1:0]        den_s4;
	logic [NUM_W-1:0]        num_s4;
	logic                    sat_s4;
	logic                    deg_s4;
	logic [SIX_VOLUME_W-1:0] sv_s4;

	logic [NUM_W-1:0]        rem_s5 [FRAC_W-1];
	logic [DEN_W-1:0]        den_s5 [FRAC_W-1];
	logic [FRAC_W-1:0]       qb_s5  [FRAC_W];
	logic                    sat_s5 [FRAC_W];
	logic                    deg_s5 [FRAC_W];
	logic [SIX_VOLUME_W-1:0] sv_s5  [FRAC_W];

	logic [FRAC_W:0]         qual_s6;
	logic                    deg_s6;
	logic [SIX_VOLUME_W-1:0] sv_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[VL-2:0], v_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			csum_s1 <= CS_W'(face[0]) + CS_W'(face[1]) + CS_W'(face[2]) + CS_W'(face[3]);
			lfx_s1  <= lfx;
			deg_s1  <= (lfx == '0) ||
			           ((face[0] == '0) && (face[1] == '0) && (face[2] == '0) &&
			            (face[3] == '0));
			nkl_s1  <= det_mag[DL_W-1:0] * K_FIXED;
			nkh_s1  <= det_mag[DETM_W-1:DL_W] * K_FIXED;
			sv_s1   <= SIX_VOLUME_W'(det_mag);

			dpl_s2 <= lfx_s1 * csum_s1[CL_W-1:0];
			dph_s2 <= lfx_s1 * csum_s1[CS_W-1:CL_W];
			nk_s2  <= NK_W'(nkl_s1) + (NK_W'(nkh_s1) << DL_W);
			deg_s2 <= deg_s1;
			sv_s2  <= sv_s1;

			den_s3 <= DEN_W'(dpl_s2) + (DEN_W'(dph_s2) << CL_W);
			num_s3 <= NUM_W'(nk_s2) << NUM_SH;
			deg_s3 <= deg_s2;
			sv_s3  <= sv_s2;

			den_s4 <= den_s3;
			num_s4 <= num_s3;
			sat_s4 <= CMP_W'(num_s3) >= (CMP_W'(den_s3) << FRAC_W);
			deg_s4 <= deg_s3;
			sv_s4  <= sv_s3;

			if (deg_s5[FRAC_W-1]) begin
				qual_s6 <= '0;
			end else if (sat_s5[FRAC_W-1]) begin
				qual_s6 <= (FRAC_W+1)'(1) << FRAC_W;
			end else begin
				qual_s6 <= {1'b0, qb_s5[FRAC_W-1]};
			end
			deg_s6 <= deg_s5[FRAC_W-1];
			sv_s6  <= sv_s5[FRAC_W-1];
		end
	end

	for (genvar j = 0; j < FRAC_W; j++) begin : g_div
		localparam int SH = FRAC_W - 1 - j;

		logic [NUM_W-1:0]        rem_in;
		logic [DEN_W-1:0]        den_in;
		logic [FRAC_W-1:0]       qb_in;
		logic                    sat_in;
		logic                    deg_in;
		logic [SIX_VOLUME_W-1:0] sv_in;
		logic [CMP_W-1:0]        dsh;
		logic                    take;

		if (j == 0) begin : g_first
			assign rem_in = num_s4;
			assign den_in = den_s4;
			assign qb_in  = '0;
			assign sat_in = sat_s4;
			assign deg_in = deg_s4;
			assign sv_in  = sv_s4;
		end else begin : g_next
			assign rem_in = rem_s5[j-1];
			assign den_in = den_s5[j-1];
			assign qb_in  = qb_s5[j-1];
			assign sat_in = sat_s5[j-1];
			assign deg_in = deg_s5[j-1];
			assign sv_in  = sv_s5[j-1];
		end

		assign dsh  = CMP_W'(den_in) << SH;
		assign take = CMP_W'(rem_in) >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				qb_s5[j]  <= qb_in | (FRAC_W'(take) << SH);
				sat_s5[j] <= sat_in;
				deg_s5[j] <= deg_in;
				sv_s5[j]  <= sv_in;
			end
		end

		if (j < FRAC_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s5[j] <= take ? NUM_W'(CMP_W'(rem_in) - dsh) : rem_in;
					den_s5[j] <= den_in;
				end
			end
		end
	end

	assign v_o        = vld_s[VL-1];
	assign quality    = qual_s6;
	assign six_volume = sv_s6;
	assign degenerate = deg_s6;

endmodule

@@ hdl/tetrahedron_shape_quality_core.sv @@
// ----------------------------------------------------------------------------
// tetrahedron_shape_quality_core: tetrahedron volume and shape quality
// Takes four corner points per transfer and returns six times the volume,
// the quality 2*sqrt(6)*D/(Lmax*C) in Q1.F and a degenerate flag.
//
// Usage:
//   Input channel in_valid/in_ready carries the twelve corner coordinates.
//   Output channel out_valid/out_ready carries shape_quality, six_volume and
//   degenerate, one result transfer per input transfer, in order.
//   The depth is set by the geometry stages, the square root lanes (one root
//   bit per stage, ROOT_W = COORD_BITS + 35) and the quotient stages (one
//   quotient bit per stage).
//   Throughput is one transfer per cycle while out_ready is high.
//   The whole pipeline advances together; a held result on the output
//   freezes every stage and drops in_ready, nothing is lost or repeated.
//   Stages holding bubbles keep the pipeline moving while out_valid is low.
//   Reset clears all valid bits; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
module tetrahedron_shape_quality_core
	import tsq_pkg::*;
#(
	parameter int COORD_BITS        = COORD_BITS_DEF,
	parameter int QUALITY_FRAC_BITS = QUALITY_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  ax,
	input  logic signed [COORD_BITS-1:0]  ay,
	input  logic signed [COORD_BITS-1:0]  az,
	input  logic signed [COORD_BITS-1:0]  bx,
	input  logic signed [COORD_BITS-1:0]  by,
	input  logic signed [COORD_BITS-1:0]  bz,
	input  logic signed [COORD_BITS-1:0]  cx,
	input  logic signed [COORD_BITS-1:0]  cy,
	input  logic signed [COORD_BITS-1:0]  cz,
	input  logic signed [COORD_BITS-1:0]  dx,
	input  logic signed [COORD_BITS-1:0]  dy,
	input  logic signed [COORD_BITS-1:0]  dz,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [QUALITY_FRAC_BITS:0]    shape_quality,
	output logic [SIX_VOLUME_W-1:0]       six_volume,
	output logic                          degenerate
);

	localparam int GB     = GUARD_SUM - COORD_BITS;
	localparam int NW     = 4 * COORD_BITS + 6;
	localparam int LW     = 2 * COORD_BITS + 2;
	localparam int ROOT_W = (NW + 2 * GB) / 2;
	localparam int LF_W   = (LW + 2 * GB) / 2;
	localparam int DETM_W = 3 * COORD_BITS + 5;
	localparam int NUM_SH = QUALITY_FRAC_BITS + 2 * GB - K_FRAC;
	localparam logic [QUALITY_FRAC_BITS:0] QMAX =
		(QUALITY_FRAC_BITS+1)'(1) << QUALITY_FRAC_BITS;

	logic                         en;
	logic signed [COORD_BITS-1:0] pt [4][3];
	logic                         geo_v;
	logic [NW-1:0]                geo_n2 [4];
	logic [LW-1:0]                geo_lmax2;
	logic [DETM_W-1:0]            geo_det;
	logic [2*ROOT_W-1:0]          rad [5];
	logic                         rt_v;
	logic [ROOT_W-1:0]            rt_root [5];
	logic [DETM_W-1:0]            rt_det;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_comb begin
		pt[0][0] = ax; pt[0][1] = ay; pt[0][2] = az;
		pt[1][0] = bx; pt[1][1] = by; pt[1][2] = bz;
		pt[2][0] = cx; pt[2][1] = cy; pt[2][2] = cz;
		pt[3][0] = dx; pt[3][1] = dy; pt[3][2] = dz;
	end

	tsq_geom #(
		.COORD_W (COORD_BITS)
	) u_geom (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_i     (in_valid),
		.pt      (pt),
		.v_o     (geo_v),
		.n2      (geo_n2),
		.lmax2   (geo_lmax2),
		.det_mag (geo_det)
	);

	always_comb begin
		for (int f = 0; f < 4; f++) begin
			rad[f] = {geo_n2[f], {(2*GB){1'b0}}};
		end
		rad[4] = (2*ROOT_W)'({geo_lmax2, {(2*GB){1'b0}}});
	end

	tsq_roots #(
		.ROOT_W (ROOT_W),
		.LANES  (5),
		.SB_W   (DETM_W)
	) u_roots (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (geo_v),
		.rad    (rad),
		.sb_i   (geo_det),
		.v_o    (rt_v),
		.root   (rt_root),
		.sb_o   (rt_det)
	);

	tsq_divider #(
		.ROOT_W (ROOT_W),
		.LF_W   (LF_W),
		.DETM_W (DETM_W),
		.FRAC_W (QUALITY_FRAC_BITS),
		.NUM_SH (NUM_SH)
	) u_divider (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.v_i        (rt_v),
		.face       (rt_root[0:3]),
		.lfx        (rt_root[4][LF_W-1:0]),
		.det_mag    (rt_det),
		.v_o        (out_valid),
		.quality    (shape_quality),
		.six_volume (six_volume),
		.degenerate (degenerate)
	);

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output stalled");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> shape_quality == '0)
		else $error("degenerate result with nonzero quality");

	a_quality_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> shape_quality <= QMAX)
		else $error("quality above 1.0");

endmodule
